[hdl/pfvs_pkg.sv]
// Package for the page frame victim selector.
// Holds the command, policy and state codes and the control structs
// shared by the frame cells, the scan unit and the top level.
package pfvs_pkg;

	// Width of the frame index ports.
	localparam int unsigned FRAME_IDX_W = 6;
	// Width of the owner fields.
	localparam int unsigned OWNER_W = 8;
	// Width of the policy register.
	localparam int unsigned POLICY_W = 2;
	// Width of the register bus data.
	localparam int unsigned APB_DATA_W = 32;
	// Width of the register bus address.
	localparam int unsigned APB_ADDR_W = 3;

	// Register index of the policy register.
	localparam logic REG_POLICY = 1'b0;

	// Commands carried by an input transfer.
	typedef enum logic [1:0] {
		CMD_SELECT = 2'd0,
		CMD_MAP    = 2'd1,
		CMD_TICK   = 2'd2
	} command_t;

	// Replacement policies.
	typedef enum logic [POLICY_W-1:0] {
		POL_RANDOM = 2'd0,
		POL_LRU    = 2'd1,
		POL_FIFO   = 2'd2
	} policy_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Per-cell controls: rotate the chain, load a mapping, age, evict.
	typedef struct packed {
		logic shift;
		logic map_en;
		logic tick_en;
		logic clr_en;
	} cell_ctrl_t;

	// Scan unit controls.
	typedef struct packed {
		logic start;
		logic step;
		logic finish;
	} scan_ctrl_t;

endpackage

[hdl/pfvs_cell.sv]
// One frame cell of the rotating frame table.
// Holds mapped, protected, age, owner and page of one frame; depends on pfvs_pkg.
module pfvs_cell #(
	parameter int unsigned PAGE_BITS = 16,
	parameter int unsigned AGE_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pfvs_pkg::cell_ctrl_t         ctrl,
	input  logic                         nb_mapped,
	input  logic                         nb_prot,
	input  logic [AGE_BITS-1:0]          nb_age,
	input  logic [pfvs_pkg::OWNER_W-1:0] nb_owner,
	input  logic [PAGE_BITS-1:0]         nb_page,
	input  logic                         map_prot,
	input  logic [pfvs_pkg::OWNER_W-1:0] map_owner,
	input  logic [PAGE_BITS-1:0]         map_page,
	input  logic                         ref_bit,
	output logic                         mapped,
	output logic                         prot,
	output logic [AGE_BITS-1:0]          age,
	output logic [pfvs_pkg::OWNER_W-1:0] owner,
	output logic [PAGE_BITS-1:0]         page
);
	import pfvs_pkg::*;

	logic                mapped_q;
	logic                prot_q;
	logic [AGE_BITS-1:0] age_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [PAGE_BITS-1:0] page_q;

	// Flags: rotation takes the neighbor, map sets, eviction clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q <= 1'b0;
			prot_q   <= 1'b0;
		end else if (ctrl.shift) begin
			mapped_q <= nb_mapped;
			prot_q   <= nb_prot;
		end else if (ctrl.map_en) begin
			mapped_q <= 1'b1;
			prot_q   <= map_prot;
		end else if (ctrl.clr_en) begin
			mapped_q <= 1'b0;
			prot_q   <= 1'b0;
		end
	end

	// Age count: cleared on map and eviction, shifted right by a tick on
	// mapped, unprotected frames with the referenced bit entering on top.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			age_q <= nb_age;
		end else if (ctrl.map_en || ctrl.clr_en) begin
			age_q <= '0;
		end else if (ctrl.tick_en && mapped_q && !prot_q) begin
			age_q <= {ref_bit, age_q[AGE_BITS-1:1]};
		end
	end

	// Owner and page; only read while the frame is mapped.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			owner_q <= nb_owner;
			page_q  <= nb_page;
		end else if (ctrl.map_en) begin
			owner_q <= map_owner;
			page_q  <= map_page;
		end
	end

	assign mapped = mapped_q;
	assign prot   = prot_q;
	assign age    = age_q;
	assign owner  = owner_q;
	assign page   = page_q;

endmodule

[hdl/pfvs_scan.sv]
// Scan unit: watches the head cell as the frame table rotates past it and
// keeps the free, policy and fallback candidates; owns the FIFO pointer.
// Depends on pfvs_pkg.
module pfvs_scan #(
	parameter int unsigned FRAME_COUNT = 64,
	parameter int unsigned PAGE_BITS   = 16,
	parameter int unsigned AGE_BITS    = 8,
	localparam int unsigned IDX_W      = $clog2(FRAME_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfvs_pkg::scan_ctrl_t          ctrl,
	input  logic [pfvs_pkg::POLICY_W-1:0] policy,
	input  logic [FRAME_COUNT-1:0]        random_bits,
	input  logic [IDX_W-1:0]              head_idx,
	input  logic                          head_mapped,
	input  logic                          head_prot,
	input  logic [AGE_BITS-1:0]           head_age,
	input  logic [pfvs_pkg::OWNER_W-1:0]  head_owner,
	input  logic [PAGE_BITS-1:0]          head_page,
	output logic                          found,
	output logic [IDX_W-1:0]              victim,
	output logic                          evict,
	output logic [pfvs_pkg::OWNER_W-1:0]  ev_owner,
	output logic [PAGE_BITS-1:0]          ev_page
);
	import pfvs_pkg::*;

	logic [FRAME_COUNT-1:0] coin_q;
	logic [IDX_W-1:0]       fifo_ptr_q;

	logic                 free_hit_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 a_hit_q;
	logic [IDX_W-1:0]     a_idx_q;
	logic [AGE_BITS-1:0]  a_age_q;
	logic [OWNER_W-1:0]   a_owner_q;
	logic [PAGE_BITS-1:0] a_page_q;
	logic                 b_hit_q;
	logic [IDX_W-1:0]     b_idx_q;
	logic [OWNER_W-1:0]   b_owner_q;
	logic [PAGE_BITS-1:0] b_page_q;

	logic cand;
	logic free_take;
	logic a_take;
	logic b_take;
	logic pick_a;
	logic pick_b;

	assign cand = !head_prot;

	// Candidate rules for the frame at the head of the chain.
	always_comb begin
		free_take = ctrl.step && cand && !head_mapped && !free_hit_q;
		a_take    = 1'b0;
		b_take    = 1'b0;
		unique case (policy)
			POL_RANDOM: begin
				a_take = ctrl.step && cand && coin_q[0] && !a_hit_q;
				b_take = ctrl.step && cand;
			end
			POL_LRU: begin
				a_take = ctrl.step && cand && head_mapped && (!a_hit_q || head_age < a_age_q);
			end
			POL_FIFO: begin
				a_take = ctrl.step && cand && (head_idx > fifo_ptr_q) && !a_hit_q;
				b_take = ctrl.step && cand && !b_hit_q;
			end
			default: begin
				a_take = 1'b0;
				b_take = 1'b0;
			end
		endcase
	end

	// Candidate flags and FIFO pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_hit_q <= 1'b0;
			a_hit_q    <= 1'b0;
			b_hit_q    <= 1'b0;
			fifo_ptr_q <= '0;
		end else if (ctrl.start) begin
			free_hit_q <= 1'b0;
			a_hit_q    <= 1'b0;
			b_hit_q    <= 1'b0;
		end else begin
			if (free_take) begin
				free_hit_q <= 1'b1;
			end
			if (a_take) begin
				a_hit_q <= 1'b1;
			end
			if (b_take) begin
				b_hit_q <= 1'b1;
			end
			if (ctrl.finish && !free_hit_q && policy == POL_FIFO && found) begin
				fifo_ptr_q <= victim;
			end
		end
	end

	// Candidate payloads and the coin line, which shifts with the chain.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			coin_q <= random_bits;
		end else if (ctrl.step) begin
			coin_q <= coin_q >> 1;
		end
		if (free_take) begin
			free_idx_q <= head_idx;
		end
		if (a_take) begin
			a_idx_q   <= head_idx;
			a_age_q   <= head_age;
			a_owner_q <= head_owner;
			a_page_q  <= head_page;
		end
		if (b_take) begin
			b_idx_q   <= head_idx;
			b_owner_q <= head_owner;
			b_page_q  <= head_page;
		end
	end

	// Final choice: a free frame first, then the policy candidate, then the
	// fallback. A policy victim is always a mapped frame.
	always_comb begin
		pick_a = !free_hit_q && a_hit_q;
		pick_b = !free_hit_q && !a_hit_q && b_hit_q;
		found  = free_hit_q || pick_a || pick_b;
		evict  = pick_a || pick_b;
		if (free_hit_q) begin
			victim = free_idx_q;
		end else if (pick_a) begin
			victim = a_idx_q;
		end else if (pick_b) begin
			victim = b_idx_q;
		end else begin
			victim = '0;
		end
		if (pick_a) begin
			ev_owner = a_owner_q;
			ev_page  = a_page_q;
		end else if (pick_b) begin
			ev_owner = b_owner_q;
			ev_page  = b_page_q;
		end else begin
			ev_owner = '0;
			ev_page  = '0;
		end
	end

endmodule

[hdl/page_frame_victim_selector.sv]
// Top level of the page frame victim selector.
// Instantiates the frame cell chain (pfvs_cell) and the scan unit (pfvs_scan);
// depends on pfvs_pkg.
//
// Usage: a command transfer is taken at a rising edge with start high and
// busy low. Map and tick complete at that edge, give no result and leave
// busy low. Select raises busy, rotates the whole frame table once through
// the cell chain, one frame past the head cell per cycle, and then presents
// one result on the result ports for a single cycle with done high.
// A select is not overlapped with the next command: a new command may be accepted
// in the cycle the result is shown, so the rate of selects is set by the full
// rotation of the chain.
// The receiver cannot stall: done is a single-cycle strobe.
// The policy register sits at byte address 0 of the APB port. The user is to write
// it only while busy is low; the block itself does not enforce this. Reset clears
// the frame flags, the FIFO pointer and the policy; no clearing pass is needed.
module page_frame_victim_selector #(
	parameter int unsigned FRAME_COUNT = 64,
	parameter int unsigned PAGE_BITS   = 16,
	parameter int unsigned AGE_BITS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pfvs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [pfvs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pfvs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        command,
	input  logic [pfvs_pkg::FRAME_IDX_W-1:0]  frame_index,
	input  logic [pfvs_pkg::OWNER_W-1:0]      owner_id,
	input  logic [PAGE_BITS-1:0]              page_number,
	input  logic                              protect_flag,
	input  logic [FRAME_COUNT-1:0]            referenced_bits,
	input  logic [FRAME_COUNT-1:0]            random_bits,
	output logic                              done,
	output logic [pfvs_pkg::FRAME_IDX_W-1:0]  victim_frame,
	output logic                              out_of_memory,
	output logic                              evicted_valid,
	output logic [pfvs_pkg::OWNER_W-1:0]      evicted_owner,
	output logic [PAGE_BITS-1:0]              evicted_page
);
	import pfvs_pkg::*;

	localparam int unsigned IDX_W = $clog2(FRAME_COUNT);

	state_t               state_q;
	state_t               state_d;
	logic [IDX_W-1:0]     cnt_q;
	logic [POLICY_W-1:0]  policy_q;
	logic                 done_q;
	logic [FRAME_IDX_W-1:0] victim_q;
	logic                 oom_q;
	logic                 ev_valid_q;
	logic [OWNER_W-1:0]   ev_owner_q;
	logic [PAGE_BITS-1:0] ev_page_q;

	logic accept;
	logic cmd_select;
	logic cmd_map;
	logic cmd_tick;
	logic scan_last;
	logic cfg_wr;

	scan_ctrl_t scan_ctrl;

	logic                 c_mapped [FRAME_COUNT];
	logic                 c_prot   [FRAME_COUNT];
	logic [AGE_BITS-1:0]  c_age    [FRAME_COUNT];
	logic [OWNER_W-1:0]   c_owner  [FRAME_COUNT];
	logic [PAGE_BITS-1:0] c_page   [FRAME_COUNT];

	logic                 sel_found;
	logic [IDX_W-1:0]     sel_victim;
	logic                 sel_evict;
	logic [OWNER_W-1:0]   sel_owner;
	logic [PAGE_BITS-1:0] sel_page;

	// Command decode.
	assign accept     = start && !busy;
	assign cmd_select = accept && (command == CMD_SELECT);
	assign cmd_map    = accept && (command == CMD_MAP);
	assign cmd_tick   = accept && (command == CMD_TICK);
	assign scan_last  = (cnt_q == IDX_W'(FRAME_COUNT - 1));

	// Register port: one policy register, no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POLICY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
		end else if (cfg_wr) begin
			policy_q <= pwdata[POLICY_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_POLICY) begin
			prdata = APB_DATA_W'(policy_q);
		end else begin
			prdata = '0;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_select) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. Busy is low in the idle state, so a select is taken
	// there whenever start is high.
	always_comb begin
		busy             = 1'b0;
		scan_ctrl.start  = 1'b0;
		scan_ctrl.step   = 1'b0;
		scan_ctrl.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				scan_ctrl.start = start && (command == CMD_SELECT);
			end
			ST_SCAN: begin
				busy           = 1'b1;
				scan_ctrl.step = 1'b1;
			end
			ST_DONE: begin
				busy             = 1'b1;
				scan_ctrl.finish = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// State and head position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (scan_ctrl.start || (scan_ctrl.step && scan_last)) begin
				cnt_q <= '0;
			end else if (scan_ctrl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Frame cell chain: cell i takes from cell i+1, the last from cell 0.
	for (genvar gi = 0; gi < FRAME_COUNT; gi++) begin : g_cell
		localparam int unsigned NB = (gi + 1) % FRAME_COUNT;
		cell_ctrl_t cctrl;

		always_comb begin
			cctrl.shift   = scan_ctrl.step;
			cctrl.map_en  = cmd_map && (frame_index == FRAME_IDX_W'(gi));
			cctrl.tick_en = cmd_tick;
			cctrl.clr_en  = scan_ctrl.finish && sel_evict && (sel_victim == IDX_W'(gi));
		end

		pfvs_cell #(
			.PAGE_BITS (PAGE_BITS),
			.AGE_BITS  (AGE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cctrl),
			.nb_mapped (c_mapped[NB]),
			.nb_prot   (c_prot[NB]),
			.nb_age    (c_age[NB]),
			.nb_owner  (c_owner[NB]),
			.nb_page   (c_page[NB]),
			.map_prot  (protect_flag),
			.map_owner (owner_id),
			.map_page  (page_number),
			.ref_bit   (referenced_bits[gi]),
			.mapped    (c_mapped[gi]),
			.prot      (c_prot[gi]),
			.age       (c_age[gi]),
			.owner     (c_owner[gi]),
			.page      (c_page[gi])
		);
	end

	// Scan unit watching the head cell.
	pfvs_scan #(
		.FRAME_COUNT (FRAME_COUNT),
		.PAGE_BITS   (PAGE_BITS),
		.AGE_BITS    (AGE_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (scan_ctrl),
		.policy      (policy_q),
		.random_bits (random_bits),
		.head_idx    (cnt_q),
		.head_mapped (c_mapped[0]),
		.head_prot   (c_prot[0]),
		.head_age    (c_age[0]),
		.head_owner  (c_owner[0]),
		.head_page   (c_page[0]),
		.found       (sel_found),
		.victim      (sel_victim),
		.evict       (sel_evict),
		.ev_owner    (sel_owner),
		.ev_page     (sel_page)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= scan_ctrl.finish;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (scan_ctrl.finish) begin
			victim_q   <= FRAME_IDX_W'(sel_victim);
			oom_q      <= !sel_found;
			ev_valid_q <= sel_evict;
			ev_owner_q <= sel_owner;
			ev_page_q  <= sel_page;
		end
	end

	assign done          = done_q;
	assign victim_frame  = victim_q;
	assign out_of_memory = oom_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_owner = ev_owner_q;
	assign evicted_page  = ev_page_q;

`ifndef SYNTHESIS
	// A result strobe follows the final sequencer state and nothing else.
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE))
		else $error("result strobe without a finished scan");

	// An out-of-memory result reports no frame and no eviction.
	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_memory) |-> (victim_frame == '0 && !evicted_valid))
		else $error("out-of-memory result carries a victim");

	// The chain is back in its home position when the choice is made.
	a_chain_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (cnt_q == '0))
		else $error("frame chain not aligned at the end of the scan");

	// A select that is accepted starts a scan in the next cycle.
	a_select_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_SELECT) |=> (state_q == ST_SCAN && busy))
		else $error("accepted select did not start a scan");
`endif

endmodule

[dv/pfvs_eviction_check.sv]
// Eviction checker for the page frame victim selector.
// Watches the APB port, command transfers and result strobes, keeps its own frame table,
// and compares each result with the oldest predicted eviction; depends on pfvs_pkg.
module pfvs_eviction_check #(
	parameter int unsigned FRAME_COUNT = 64,
	parameter int unsigned PAGE_BITS   = 16,
	parameter int unsigned AGE_BITS    = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [pfvs_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pfvs_pkg::APB_DATA_W-1:0]     pwdata,
	input  logic [pfvs_pkg::APB_DATA_W-1:0]     prdata,
	input  logic                                start,
	input  logic                                busy,
	input  logic [1:0]                          command,
	input  logic [pfvs_pkg::FRAME_IDX_W-1:0]    frame_index,
	input  logic [pfvs_pkg::OWNER_W-1:0]        owner_id,
	input  logic [PAGE_BITS-1:0]                page_number,
	input  logic                                protect_flag,
	input  logic [FRAME_COUNT-1:0]              referenced_bits,
	input  logic [FRAME_COUNT-1:0]              random_bits,
	input  logic                                done,
	input  logic [pfvs_pkg::FRAME_IDX_W-1:0]    victim_frame,
	input  logic                                out_of_memory,
	input  logic                                evicted_valid,
	input  logic [pfvs_pkg::OWNER_W-1:0]        evicted_owner,
	input  logic [PAGE_BITS-1:0]                evicted_page,
	output int                                  outstanding,
	output int                                  errors,
	output int                                  results_checked,
	output int                                  oom_count
);
	import pfvs_pkg::*;

	localparam logic [APB_ADDR_W-1:0] POLICY_ADDR = APB_ADDR_W'(4 * REG_POLICY);

	// One predicted select outcome.
	typedef struct packed {
		logic [FRAME_IDX_W-1:0] victim;
		logic                   oom;
		logic                   ev_valid;
		logic [OWNER_W-1:0]     ev_owner;
		logic [PAGE_BITS-1:0]   ev_page;
	} eviction_t;

	// Shadow frame table and policy.
	logic                   tbl_mapped    [FRAME_COUNT];
	logic                   tbl_protected [FRAME_COUNT];
	logic [AGE_BITS-1:0]    tbl_age       [FRAME_COUNT];
	logic [OWNER_W-1:0]     tbl_owner     [FRAME_COUNT];
	logic [PAGE_BITS-1:0]   tbl_page      [FRAME_COUNT];
	logic [FRAME_IDX_W-1:0] fifo_ptr;
	logic [POLICY_W-1:0]    policy;

	eviction_t pending_evictions [$];
	eviction_t head_ev;
	int        waiting;
	int        err_count;
	int        seen_count;
	int        seen_oom;

	task automatic clear_table();
		for (int i = 0; i < FRAME_COUNT; i++) begin
			tbl_mapped[i]    = 1'b0;
			tbl_protected[i] = 1'b0;
			tbl_age[i]       = '0;
			tbl_owner[i]     = '0;
			tbl_page[i]      = '0;
		end
		fifo_ptr = '0;
		policy   = POL_RANDOM;
	endtask

	// Picks the victim for a select, frees it and returns what the block must report.
	function automatic eviction_t select_victim(logic [FRAME_COUNT-1:0] coins);
		eviction_t res;
		int        pick;
		int        last_open;
		int        cand;
		bit        found;
		logic [AGE_BITS-1:0] least;
		res       = '0;
		pick      = 0;
		last_open = -1;
		found     = 1'b0;
		least     = '0;
		// A free, unprotected frame always wins, whatever the policy.
		for (int i = 0; i < FRAME_COUNT; i++) begin
			if (!found && !tbl_protected[i] && !tbl_mapped[i]) begin
				pick  = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			case (policy)
				POL_RANDOM: begin
					for (int i = 0; i < FRAME_COUNT; i++) begin
						if (!found && !tbl_protected[i]) begin
							last_open = i;
							if (coins[i]) begin
								pick  = i;
								found = 1'b1;
							end
						end
					end
					if (!found && last_open >= 0) begin
						pick  = last_open;
						found = 1'b1;
					end
				end
				POL_LRU: begin
					for (int i = 0; i < FRAME_COUNT; i++) begin
						if (!tbl_protected[i] && tbl_mapped[i] && (!found || tbl_age[i] < least)) begin
							least = tbl_age[i];
							pick  = i;
							found = 1'b1;
						end
					end
				end
				POL_FIFO: begin
					cand = (int'(fifo_ptr) + 1) % FRAME_COUNT;
					for (int i = 0; i < FRAME_COUNT; i++) begin
						if (!found) begin
							if (!tbl_protected[cand]) begin
								pick  = cand;
								found = 1'b1;
							end else begin
								cand = (cand + 1) % FRAME_COUNT;
							end
						end
					end
					if (found)
						fifo_ptr = FRAME_IDX_W'(pick);
				end
				default: begin
					// The unused policy never finds a victim once the table is full.
				end
			endcase
		end
		if (!found) begin
			res.oom = 1'b1;
		end else begin
			res.victim = FRAME_IDX_W'(pick);
			if (tbl_mapped[pick]) begin
				res.ev_valid        = 1'b1;
				res.ev_owner        = tbl_owner[pick];
				res.ev_page         = tbl_page[pick];
				tbl_mapped[pick]    = 1'b0;
				tbl_protected[pick] = 1'b0;
				tbl_age[pick]       = '0;
				tbl_owner[pick]     = '0;
				tbl_page[pick]      = '0;
			end
		end
		return res;
	endfunction

	// Results are checked before the transfer of the same edge is predicted,
	// since a new command may be taken in the cycle a result is shown.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			pending_evictions.delete();
			waiting    = 0;
			err_count  = 0;
			seen_count = 0;
			seen_oom   = 0;
		end else begin
			if (done) begin
				if (waiting == 0) begin
					$error("result with no select pending: victim_frame %0d", victim_frame);
					err_count++;
				end else begin
					head_ev = pending_evictions.pop_front();
					waiting--;
					seen_count++;
					if (out_of_memory)
						seen_oom++;
					if (victim_frame !== head_ev.victim) begin
						$error("victim_frame: expected %0d, actual %0d", head_ev.victim, victim_frame);
						err_count++;
					end
					if (out_of_memory !== head_ev.oom) begin
						$error("out_of_memory: expected %0d, actual %0d", head_ev.oom, out_of_memory);
						err_count++;
					end
					if (evicted_valid !== head_ev.ev_valid) begin
						$error("evicted_valid: expected %0d, actual %0d",
							head_ev.ev_valid, evicted_valid);
						err_count++;
					end
					if (evicted_owner !== head_ev.ev_owner) begin
						$error("evicted_owner: expected 0x%0h, actual 0x%0h",
							head_ev.ev_owner, evicted_owner);
						err_count++;
					end
					if (evicted_page !== head_ev.ev_page) begin
						$error("evicted_page: expected 0x%0h, actual 0x%0h",
							head_ev.ev_page, evicted_page);
						err_count++;
					end
				end
			end

			// Register read at the access phase returns the policy.
			if (psel && penable && !pwrite && pready && paddr == POLICY_ADDR) begin
				if (prdata !== APB_DATA_W'(policy)) begin
					$error("prdata: expected 0x%0h, actual 0x%0h", policy, prdata);
					err_count++;
				end
			end

			// Register write at the access phase.
			if (psel && penable && pwrite && pready && paddr == POLICY_ADDR)
				policy = pwdata[POLICY_W-1:0];

			// Command transfer.
			if (start && !busy) begin
				case (command)
					CMD_SELECT: begin
						pending_evictions.push_back(select_victim(random_bits));
						waiting++;
					end
					CMD_MAP: begin
						if (frame_index < FRAME_COUNT) begin
							tbl_mapped[frame_index]    = 1'b1;
							tbl_protected[frame_index] = protect_flag;
							tbl_owner[frame_index]     = owner_id;
							tbl_page[frame_index]      = page_number;
							tbl_age[frame_index]       = '0;
						end
					end
					CMD_TICK: begin
						for (int i = 0; i < FRAME_COUNT; i++) begin
							if (tbl_mapped[i] && !tbl_protected[i])
								tbl_age[i] = {referenced_bits[i], tbl_age[i][AGE_BITS-1:1]};
						end
					end
					default: begin
						// The unused command is ignored.
					end
				endcase
			end
		end
		outstanding     <= waiting;
		errors          <= err_count;
		results_checked <= seen_count;
		oom_count       <= seen_oom;
	end

endmodule

[dv/testbench.sv]
// Top of the page frame victim selector testbench: clock, reset, APB policy
// writes and command stimulus, with the verdict taken from pfvs_eviction_check.
// Depends on pfvs_pkg, page_frame_victim_selector and pfvs_eviction_check.
module testbench;
	import pfvs_pkg::*;

	localparam int unsigned FRAME_COUNT = 64;
	localparam int unsigned PAGE_BITS   = 16;
	localparam int unsigned AGE_BITS    = 8;
	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = FRAME_COUNT + 4;
	localparam int CYCLE_LIMIT   = 250000;
	localparam int MIX_ITEMS     = 30;
	localparam logic [1:0]            CMD_UNUSED  = 2'd3;
	localparam logic [POLICY_W-1:0]   POL_UNUSED  = 2'd3;
	localparam logic [APB_ADDR_W-1:0] POLICY_ADDR = APB_ADDR_W'(4 * REG_POLICY);

	logic                   clk             = 1'b0;
	logic                   arst_n          = 1'b0;
	logic                   psel            = 1'b0;
	logic                   penable         = 1'b0;
	logic                   pwrite          = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr           = '0;
	logic [APB_DATA_W-1:0]  pwdata          = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   start           = 1'b0;
	logic                   busy;
	logic [1:0]             command         = CMD_SELECT;
	logic [FRAME_IDX_W-1:0] frame_index     = '0;
	logic [OWNER_W-1:0]     owner_id        = '0;
	logic [PAGE_BITS-1:0]   page_number     = '0;
	logic                   protect_flag    = 1'b0;
	logic [FRAME_COUNT-1:0] referenced_bits = '0;
	logic [FRAME_COUNT-1:0] random_bits     = '0;
	logic                   done;
	logic [FRAME_IDX_W-1:0] victim_frame;
	logic                   out_of_memory;
	logic                   evicted_valid;
	logic [OWNER_W-1:0]     evicted_owner;
	logic [PAGE_BITS-1:0]   evicted_page;

	int outstanding;
	int errors;
	int results_checked;
	int oom_count;
	int cycles;
	int sent_map;
	int sent_tick;
	int sent_noise;
	bit burst;
	bit have_freed;
	logic [FRAME_IDX_W-1:0] last_freed;

	always #(CLK_HALF) clk = ~clk;

	page_frame_victim_selector #(
		.FRAME_COUNT (FRAME_COUNT),
		.PAGE_BITS   (PAGE_BITS),
		.AGE_BITS    (AGE_BITS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.frame_index     (frame_index),
		.owner_id        (owner_id),
		.page_number     (page_number),
		.protect_flag    (protect_flag),
		.referenced_bits (referenced_bits),
		.random_bits     (random_bits),
		.done            (done),
		.victim_frame    (victim_frame),
		.out_of_memory   (out_of_memory),
		.evicted_valid   (evicted_valid),
		.evicted_owner   (evicted_owner),
		.evicted_page    (evicted_page)
	);

	pfvs_eviction_check #(
		.FRAME_COUNT (FRAME_COUNT),
		.PAGE_BITS   (PAGE_BITS),
		.AGE_BITS    (AGE_BITS)
	) u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.frame_index     (frame_index),
		.owner_id        (owner_id),
		.page_number     (page_number),
		.protect_flag    (protect_flag),
		.referenced_bits (referenced_bits),
		.random_bits     (random_bits),
		.done            (done),
		.victim_frame    (victim_frame),
		.out_of_memory   (out_of_memory),
		.evicted_valid   (evicted_valid),
		.evicted_owner   (evicted_owner),
		.evicted_page    (evicted_page),
		.outstanding     (outstanding),
		.errors          (errors),
		.results_checked (results_checked),
		.oom_count       (oom_count)
	);

	// Remember the last freed frame so that maps can refill it and keep the table full.
	always @(posedge clk) begin
		if (done && !out_of_memory) begin
			last_freed <= victim_frame;
			have_freed <= 1'b1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Bit pattern for coins or referenced bits: empty, full, one hot or random.
	function automatic logic [63:0] bit_pattern();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return rand64();
		endcase
	endfunction

	// Drives one command transfer after a random gap and waits until it is taken.
	task automatic issue(logic [1:0] cmd, logic [FRAME_IDX_W-1:0] idx, logic [OWNER_W-1:0] own,
			logic [PAGE_BITS-1:0] pg, logic prot, logic [63:0] refs, logic [63:0] coins);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 15) == 0)
			burst = !burst;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		command         <= cmd;
		frame_index     <= idx;
		owner_id        <= own;
		page_number     <= pg;
		protect_flag    <= prot;
		referenced_bits <= refs;
		random_bits     <= coins;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (cmd)
			CMD_MAP:  sent_map++;
			CMD_TICK: sent_tick++;
			CMD_SELECT: ;
			default:  sent_noise++;
		endcase
	endtask

	task automatic map_frame(logic [FRAME_IDX_W-1:0] idx, logic prot);
		issue(CMD_MAP, idx, OWNER_W'($urandom), PAGE_BITS'($urandom), prot, rand64(), rand64());
	endtask

	task automatic select_frame(logic [63:0] coins);
		issue(CMD_SELECT, FRAME_IDX_W'($urandom), OWNER_W'($urandom), PAGE_BITS'($urandom),
			1'($urandom), rand64(), coins);
	endtask

	task automatic tick_ages(logic [63:0] refs);
		issue(CMD_TICK, FRAME_IDX_W'($urandom), OWNER_W'($urandom), PAGE_BITS'($urandom),
			1'($urandom), refs, rand64());
	endtask

	// Waits for the block to drain, writes the policy register and reads it back.
	task automatic set_policy(logic [POLICY_W-1:0] pol);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= POLICY_ADDR;
		pwdata  <= APB_DATA_W'(pol);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic fill_table(bit all_protected);
		for (int i = 0; i < FRAME_COUNT; i++)
			map_frame(FRAME_IDX_W'(i), all_protected ? 1'b1 : ($urandom_range(0, 7) == 0));
	endtask

	// Mostly selects, refills of the freed frame and ticks, with a little noise.
	task automatic mixed_items(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				select_frame(bit_pattern());
			else if (r < 65)
				map_frame((have_freed && $urandom_range(0, 9) < 7) ? last_freed
					: FRAME_IDX_W'($urandom_range(0, FRAME_COUNT - 1)), $urandom_range(0, 7) == 0);
			else if (r < 95)
				tick_ages(bit_pattern());
			else
				issue(CMD_UNUSED, FRAME_IDX_W'($urandom), OWNER_W'($urandom),
					PAGE_BITS'($urandom), 1'($urandom), rand64(), rand64());
		end
	endtask

	// Run limit.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("page_frame_victim_selector verification failed");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset policy: empty table, field extremes, ticks,
		// the unused command, free frame selection, and protect and unprotect by remap.
		select_frame('0);
		issue(CMD_MAP, 6'd0, 8'hff, 16'hffff, 1'b0, '0, '0);
		issue(CMD_MAP, 6'd63, 8'h00, 16'h0000, 1'b1, '1, '1);
		issue(CMD_MAP, 6'd1, 8'h5a, 16'ha5a5, 1'b0, 64'h5555_5555_5555_5555, '0);
		tick_ages('1);
		tick_ages('0);
		tick_ages(64'haaaa_aaaa_aaaa_aaaa);
		issue(CMD_UNUSED, 6'd63, 8'hff, 16'hffff, 1'b1, '1, '1);
		select_frame('1);
		issue(CMD_MAP, 6'd63, 8'h81, 16'h8001, 1'b0, '0, '0);
		issue(CMD_MAP, 6'd0, 8'h7e, 16'h7ffe, 1'b1, '0, '0);
		select_frame('0);

		// Aging LRU over a full table.
		set_policy(POL_LRU);
		fill_table(1'b0);
		mixed_items(MIX_ITEMS);

		set_policy(POL_FIFO);
		mixed_items(MIX_ITEMS);

		set_policy(POL_RANDOM);
		mixed_items(MIX_ITEMS);

		// The unused policy reports out of memory while the table is full.
		set_policy(POL_UNUSED);
		mixed_items(20);

		// Every frame protected: each select finds nothing.
		set_policy(POL_FIFO);
		fill_table(1'b1);
		select_frame(rand64());
		select_frame('0);
		select_frame('1);
		fill_table(1'b0);
		mixed_items(MIX_ITEMS);

		// Saturated counts: LRU must still pick among frames aged to the maximum.
		set_policy(POL_LRU);
		fill_table(1'b0);
		repeat (AGE_BITS + 1) tick_ages('1);
		select_frame(rand64());
		select_frame(rand64());
		mixed_items(MIX_ITEMS);

		// Drain and let the last select settle.
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d select results (%0d out of memory) against %0d maps, %0d ticks",
			results_checked, oom_count, sent_map, sent_tick);
		$display("and %0d ignored commands, under random, aging LRU, FIFO and the unused policy.",
			sent_noise);
		if (errors == 0 && outstanding == 0)
			$display("page_frame_victim_selector verification clean");
		else
			$display("page_frame_victim_selector verification failed");
		$finish;
	end

endmodule
